### rtl/esfa_pkg.sv
package esfa_pkg;

   localparam int ID_W   = 10;
   localparam int KIND_W = 3;
   localparam int TYPE_W = 8;
   localparam int TIME_W = 32;
   localparam int ANN_W  = 2;

   localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SPAWN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GET     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DESPAWN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 3'd4;

   localparam logic [ANN_W-1:0] ANN_NONE    = 2'd0;
   localparam logic [ANN_W-1:0] ANN_SPAWN   = 2'd1;
   localparam logic [ANN_W-1:0] ANN_DESPAWN = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   next;
      logic [TYPE_W-1:0] kind;
      logic [TIME_W-1:0] spawn;
      logic [TIME_W-1:0] despawn;
   } slot_word_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   slot_id;
      logic [TYPE_W-1:0] new_type;
      logic [TIME_W-1:0] time_now;
   } op_type;

   typedef struct packed {
      logic [ID_W-1:0]   result_id;
      logic              live;
      logic [TYPE_W-1:0] slot_type;
      logic [TIME_W-1:0] spawn_time;
      logic [TIME_W-1:0] despawn_time;
      logic [ANN_W-1:0]  announce;
      logic              out_of_range;
   } rsp_type;

   typedef struct packed {
      logic            wr_en;
      logic [ID_W-1:0] wr_addr;
      logic            head_en;
      logic [ID_W-1:0] head_val;
   } ctl_type;

endpackage

### rtl/entity_slot_freelist_allocator_core.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  kind, slot_id, new_type, time_now
// rsp       out        rsp_valid/rsp_stall  result_id, live, slot_type, spawn_time,
//                                           despawn_time, announce, out_of_range
//
// a request is accepted with the slot memory read, then in the execute step it is modified,
// written back and loaded into the response register; the registered memory read lies
// ahead of the write back
// after reset a clearing pass writes every slot, with req_stall high
// a new request is accepted while a response still waits in the output register
// a stalled response holds the execute step until the output register frees
module entity_slot_freelist_allocator_core #(
   parameter int ENTITIES = 256,
   parameter int PLAYERS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [9:0]  req_slot_id,
   input  logic [7:0]  req_new_type,
   input  logic [31:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_result_id,
   output logic        rsp_live,
   output logic [7:0]  rsp_slot_type,
   output logic [31:0] rsp_spawn_time,
   output logic [31:0] rsp_despawn_time,
   output logic [1:0]  rsp_announce,
   output logic        rsp_out_of_range
);

   localparam int ID_W  = esfa_pkg::ID_W;
   localparam int IDX_W = $clog2(ENTITIES);
   localparam logic [ID_W-1:0] HEAD_INIT =
      (PLAYERS + 1 < ENTITIES) ? ID_W'(PLAYERS + 1) : '0;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [ID_W-1:0]  free_head_ff, free_head_in;
   logic             rsp_valid_ff, rsp_valid_in;
   esfa_pkg::rsp_type rsp_ff, rsp_in;
   esfa_pkg::op_type  op_ff, op_in;

   esfa_pkg::slot_word_type mem [ENTITIES];
   esfa_pkg::slot_word_type rd_data_ff;
   esfa_pkg::slot_word_type upd_word;
   esfa_pkg::slot_word_type clr_word;
   esfa_pkg::slot_word_type wr_data;
   esfa_pkg::ctl_type       upd_ctl;
   esfa_pkg::rsp_type       upd_rsp;

   logic             accept;
   logic             fire;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;

   esfa_slot_update #(
      .ENTITIES(ENTITIES)
   ) u_update (
      .op      (op_ff),
      .rd_word (rd_data_ff),
      .head    (free_head_ff),
      .wr_word (upd_word),
      .ctl     (upd_ctl),
      .rsp     (upd_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // chain value for the slot being cleared
   always_comb begin
      clr_word = '0;
      if ((32'(clr_ff) >= PLAYERS + 1) && (32'(clr_ff) + 1 < ENTITIES)) begin
         clr_word.next = ID_W'(clr_ff) + 10'd1;
      end
   end

   assign rd_en   = accept;
   assign rd_addr = (req_kind == esfa_pkg::KIND_CREATE) ? free_head_ff[IDX_W-1:0]
                                                        : req_slot_id[IDX_W-1:0];
   assign wr_en   = (state_ff == ST_CLEAR) || (fire && upd_ctl.wr_en);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : upd_ctl.wr_addr[IDX_W-1:0];
   assign wr_data = (state_ff == ST_CLEAR) ? clr_word : upd_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      free_head_in = free_head_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(ENTITIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in.kind     = req_kind;
               op_in.slot_id  = req_slot_id;
               op_in.new_type = req_new_type;
               op_in.time_now = req_time_now;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               rsp_in       = upd_rsp;
               rsp_valid_in = 1'b1;
               if (upd_ctl.head_en) begin
                  free_head_in = upd_ctl.head_val;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= HEAD_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      op_ff  <= op_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_ff.result_id;
   assign rsp_live         = rsp_ff.live;
   assign rsp_slot_type    = rsp_ff.slot_type;
   assign rsp_spawn_time   = rsp_ff.spawn_time;
   assign rsp_despawn_time = rsp_ff.despawn_time;
   assign rsp_announce     = rsp_ff.announce;
   assign rsp_out_of_range = rsp_ff.out_of_range;

   a_head_legal: assert property (@(posedge clock) disable iff (reset)
      free_head_ff == '0 || (free_head_ff > PLAYERS && free_head_ff < ENTITIES))
      else $error("free list head outside the allocatable range");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted request did not move to execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("response appeared without an execute step");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff && req_stall)
      else $error("activity during the clearing pass");

endmodule

### rtl/esfa_slot_update.sv
module esfa_slot_update #(
   parameter int ENTITIES = 256
) (
   input  esfa_pkg::op_type        op,
   input  esfa_pkg::slot_word_type rd_word,
   input  logic [esfa_pkg::ID_W-1:0] head,
   output esfa_pkg::slot_word_type wr_word,
   output esfa_pkg::ctl_type       ctl,
   output esfa_pkg::rsp_type       rsp
);

   always_comb begin
      ctl     = '0;
      wr_word = rd_word;
      rsp     = '0;
      if (op.kind == esfa_pkg::KIND_CREATE) begin
         if (head != '0 && head < ENTITIES) begin
            ctl.wr_en        = 1'b1;
            ctl.wr_addr      = head;
            ctl.head_en      = 1'b1;
            ctl.head_val     = rd_word.next;
            wr_word.next     = '0;
            wr_word.kind     = op.new_type;
            rsp.result_id    = head;
            rsp.live         = (op.new_type != '0);
            rsp.slot_type    = op.new_type;
            rsp.spawn_time   = rd_word.spawn;
            rsp.despawn_time = rd_word.despawn;
         end
      end else begin
         rsp.result_id = op.slot_id;
         ctl.wr_addr   = op.slot_id;
         if (op.slot_id >= ENTITIES) begin
            rsp.out_of_range = 1'b1;
         end else begin
            if (rd_word.kind != '0) begin
               case (op.kind)
                  esfa_pkg::KIND_SPAWN: begin
                     wr_word.spawn = op.time_now;
                     rsp.announce  = esfa_pkg::ANN_SPAWN;
                     ctl.wr_en     = 1'b1;
                  end
                  esfa_pkg::KIND_DESPAWN: begin
                     wr_word.despawn = op.time_now;
                     rsp.announce    = esfa_pkg::ANN_DESPAWN;
                     ctl.wr_en       = 1'b1;
                  end
                  esfa_pkg::KIND_DESTROY: begin
                     wr_word.kind    = '0;
                     wr_word.spawn   = '0;
                     wr_word.despawn = '0;
                     wr_word.next    = head;
                     ctl.wr_en       = 1'b1;
                     ctl.head_en     = 1'b1;
                     ctl.head_val    = op.slot_id;
                  end
                  default: begin
                  end
               endcase
            end
            rsp.live         = (wr_word.kind != '0);
            rsp.slot_type    = wr_word.kind;
            rsp.spawn_time   = wr_word.spawn;
            rsp.despawn_time = wr_word.despawn;
         end
      end
   end

endmodule

### dv/slot_alloc_checker.sv
module slot_alloc_checker
   import esfa_pkg::*;
#(
   parameter int ENTITIES = 256,
   parameter int PLAYERS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [ID_W-1:0]   req_slot_id,
   input  logic [TYPE_W-1:0] req_new_type,
   input  logic [TIME_W-1:0] req_time_now,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [ID_W-1:0]   rsp_result_id,
   input  logic              rsp_live,
   input  logic [TYPE_W-1:0] rsp_slot_type,
   input  logic [TIME_W-1:0] rsp_spawn_time,
   input  logic [TIME_W-1:0] rsp_despawn_time,
   input  logic [ANN_W-1:0]  rsp_announce,
   input  logic              rsp_out_of_range,
   output int                error_count,
   output int                pending_count,
   output int                checked_count,
   output int                empty_create_count,
   output int                announce_count,
   output int                out_of_range_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = $clog2(ENTITIES);

   logic [ID_W-1:0]   free_head;
   logic [ID_W-1:0]   next_free   [ENTITIES];
   logic [TYPE_W-1:0] kind_tab    [ENTITIES];
   logic [TIME_W-1:0] spawn_tab   [ENTITIES];
   logic [TIME_W-1:0] despawn_tab [ENTITIES];

   rsp_type expected_rsp_q [$];

   int errors;
   int checked;
   int empty_creates;
   int announces;
   int oor_hits;

   function automatic rsp_type apply_slot_op(input op_type op);
      rsp_type          r;
      logic [ID_W-1:0]  got;
      logic [ID_W-1:0]  id;
      logic [IDX_W-1:0] gi;
      logic [IDX_W-1:0] ii;
      r  = '0;
      id = op.slot_id;
      ii = id[IDX_W-1:0];
      if (op.kind == KIND_CREATE) begin
         got = free_head;
         gi  = got[IDX_W-1:0];
         if (got != '0 && int'(got) < ENTITIES) begin
            free_head      = next_free[gi];
            next_free[gi]  = '0;
            kind_tab[gi]   = op.new_type;
            r.result_id    = got;
            r.live         = (kind_tab[gi] != '0);
            r.slot_type    = kind_tab[gi];
            r.spawn_time   = spawn_tab[gi];
            r.despawn_time = despawn_tab[gi];
         end
         return r;
      end
      r.result_id = id;
      if (int'(id) >= ENTITIES) begin
         r.out_of_range = 1'b1;
         return r;
      end
      if (kind_tab[ii] != '0) begin
         case (op.kind)
            KIND_SPAWN: begin
               spawn_tab[ii] = op.time_now;
               r.announce    = ANN_SPAWN;
            end
            KIND_DESPAWN: begin
               despawn_tab[ii] = op.time_now;
               r.announce      = ANN_DESPAWN;
            end
            KIND_DESTROY: begin
               kind_tab[ii]    = '0;
               spawn_tab[ii]   = '0;
               despawn_tab[ii] = '0;
               next_free[ii]   = free_head;
               free_head       = id;
            end
            default: ;
         endcase
      end
      r.live         = (kind_tab[ii] != '0);
      r.slot_type    = kind_tab[ii];
      r.spawn_time   = spawn_tab[ii];
      r.despawn_time = despawn_tab[ii];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      op_type  op;
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         free_head = (PLAYERS + 1 < ENTITIES) ? ID_W'(PLAYERS + 1) : '0;
         for (int i = 0; i < ENTITIES; i++) begin
            next_free[IDX_W'(i)]   = (i >= PLAYERS + 1 && i + 1 < ENTITIES) ?
                                     ID_W'(i + 1) : '0;
            kind_tab[IDX_W'(i)]    = '0;
            spawn_tab[IDX_W'(i)]   = '0;
            despawn_tab[IDX_W'(i)] = '0;
         end
         expected_rsp_q.delete();
         errors        = 0;
         checked       = 0;
         empty_creates = 0;
         announces     = 0;
         oor_hits      = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_result_id, rsp_live, rsp_slot_type, rsp_spawn_time,
                     rsp_despawn_time, rsp_announce, rsp_out_of_range};
            if (expected_rsp_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with no request pending, id=%0d",
                           $realtime, rsp_result_id);
            end else begin
               want = expected_rsp_q.pop_front();
               checked++;
               if (seen !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch", $realtime);
                     $display("   expected id=%0d live=%0b type=%0d spawn=%h despawn=%h ann=%0d oor=%0b",
                              want.result_id, want.live, want.slot_type, want.spawn_time,
                              want.despawn_time, want.announce, want.out_of_range);
                     $display("   actual   id=%0d live=%0b type=%0d spawn=%h despawn=%h ann=%0d oor=%0b",
                              seen.result_id, seen.live, seen.slot_type, seen.spawn_time,
                              seen.despawn_time, seen.announce, seen.out_of_range);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            op   = '{req_kind, req_slot_id, req_new_type, req_time_now};
            want = apply_slot_op(op);
            if (op.kind == KIND_CREATE && want.result_id == '0)
               empty_creates++;
            if (want.announce != ANN_NONE)
               announces++;
            if (want.out_of_range)
               oor_hits++;
            expected_rsp_q.push_back(want);
         end
      end
      error_count        <= errors;
      pending_count      <= expected_rsp_q.size();
      checked_count      <= checked;
      empty_create_count <= empty_creates;
      announce_count     <= announces;
      out_of_range_count <= oor_hits;
   end

endmodule

### dv/testbench.sv
module testbench;
   import esfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTITIES   = 256;
   localparam int PLAYERS    = 16;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT  = 4000;
   localparam int POOL_SIZE   = 64;
   localparam int POOL_W      = $clog2(POOL_SIZE);

   // kinds outside the defined set, handled like get
   localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   localparam logic [ID_W-1:0] FIRST_FREE = ID_W'(PLAYERS + 1);
   localparam logic [ID_W-1:0] ID_MAX     = '1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = KIND_GET;
   logic [ID_W-1:0]   req_slot_id = '0;
   logic [TYPE_W-1:0] req_new_type = '0;
   logic [TIME_W-1:0] req_time_now = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ID_W-1:0]   rsp_result_id;
   logic              rsp_live;
   logic [TYPE_W-1:0] rsp_slot_type;
   logic [TIME_W-1:0] rsp_spawn_time;
   logic [TIME_W-1:0] rsp_despawn_time;
   logic [ANN_W-1:0]  rsp_announce;
   logic              rsp_out_of_range;

   int error_count;
   int pending_count;
   int checked_count;
   int empty_create_count;
   int announce_count;
   int out_of_range_count;

   int sent_count = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   bit no_idle = 1'b0;

   // slots recently seen live, used to aim requests at allocated entities
   logic [ID_W-1:0] live_ids [POOL_SIZE] = '{default: FIRST_FREE};
   int              live_wr = 0;

   always #10 clock = ~clock;

   entity_slot_freelist_allocator_core #(
      .ENTITIES(ENTITIES),
      .PLAYERS (PLAYERS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_slot_id     (req_slot_id),
      .req_new_type    (req_new_type),
      .req_time_now    (req_time_now),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_id   (rsp_result_id),
      .rsp_live        (rsp_live),
      .rsp_slot_type   (rsp_slot_type),
      .rsp_spawn_time  (rsp_spawn_time),
      .rsp_despawn_time(rsp_despawn_time),
      .rsp_announce    (rsp_announce),
      .rsp_out_of_range(rsp_out_of_range)
   );

   slot_alloc_checker #(
      .ENTITIES(ENTITIES),
      .PLAYERS (PLAYERS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_slot_id       (req_slot_id),
      .req_new_type      (req_new_type),
      .req_time_now      (req_time_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_id     (rsp_result_id),
      .rsp_live          (rsp_live),
      .rsp_slot_type     (rsp_slot_type),
      .rsp_spawn_time    (rsp_spawn_time),
      .rsp_despawn_time  (rsp_despawn_time),
      .rsp_announce      (rsp_announce),
      .rsp_out_of_range  (rsp_out_of_range),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .empty_create_count(empty_create_count),
      .announce_count    (announce_count),
      .out_of_range_count(out_of_range_count)
   );

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && rsp_live) begin
         live_ids[live_wr[POOL_W-1:0]] <= rsp_result_id;
         live_wr <= live_wr + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(input int create_pct, input int destroy_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < create_pct) return KIND_CREATE;
      if (r < create_pct + destroy_pct) return KIND_DESTROY;
      case ($urandom_range(0, 9))
         0:       return KIND_W'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
         1, 2, 3: return KIND_SPAWN;
         4, 5:    return KIND_GET;
         default: return KIND_DESPAWN;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return live_ids[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
      if (r < 75) return ID_W'($urandom_range(0, ENTITIES - 1));
      if (r < 85) return ID_W'($urandom_range(ENTITIES, int'(ID_MAX)));
      if (r < 90) return ID_W'($urandom_range(0, PLAYERS));
      return ID_W'($urandom_range(PLAYERS + 1, PLAYERS + 40));
   endfunction

   function automatic logic [TYPE_W-1:0] pick_type();
      if ($urandom_range(0, 99) < 15) return '0;
      return TYPE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom();
   endfunction

   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                           input logic [TYPE_W-1:0] ntype, input logic [TIME_W-1:0] tnow);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_slot_id  <= id;
      req_new_type <= ntype;
      req_time_now <= tnow;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic random_phase(input int count, input int create_pct, input int destroy_pct);
      for (int n = 0; n < count; n++)
         send_req(pick_kind(create_pct, destroy_pct), pick_id(), pick_type(), pick_time());
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin : rsp_driver
      @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (no_idle || $urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (1 + pick_gap()) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: first creates take slots PLAYERS+1 onward
      send_req(KIND_CREATE,  '0,                  8'hFF, 32'h1234_5678);
      send_req(KIND_CREATE,  '0,                  8'h00, 32'h0);
      send_req(KIND_CREATE,  '0,                  8'h01, 32'h0);
      send_req(KIND_SPAWN,   FIRST_FREE,          8'h00, 32'hFFFF_FFFF);
      send_req(KIND_DESPAWN, FIRST_FREE,          8'hFF, 32'h0000_0000);
      send_req(KIND_GET,     FIRST_FREE,          8'h00, 32'h0);
      // type-zero slot is not live
      send_req(KIND_SPAWN,   ID_W'(FIRST_FREE + 1), 8'h00, 32'hAAAA_5555);
      send_req(KIND_DESPAWN, ID_W'(FIRST_FREE + 1), 8'h00, 32'h5555_AAAA);
      send_req(KIND_DESTROY, ID_W'(FIRST_FREE + 1), 8'h00, 32'h0);
      send_req(KIND_GET,     '0,                  8'h00, 32'h0);
      send_req(KIND_GET,     ID_W'(PLAYERS),      8'h00, 32'h0);
      send_req(KIND_GET,     ID_W'(ENTITIES - 1), 8'h00, 32'h0);
      // out of range ids
      send_req(KIND_GET,     ID_W'(ENTITIES),     8'h00, 32'h0);
      send_req(KIND_SPAWN,   ID_MAX,              8'hFF, 32'hFFFF_FFFF);
      send_req(KIND_DESTROY, ID_MAX,              8'h00, 32'h0);
      // destroy then reuse, stamps come back cleared
      send_req(KIND_DESPAWN, ID_W'(FIRST_FREE + 2), 8'h00, 32'h8000_0001);
      send_req(KIND_DESTROY, ID_W'(FIRST_FREE + 2), 8'h00, 32'h0);
      send_req(KIND_CREATE,  '0,                  8'h80, 32'h0);
      send_req(KIND_GET,     ID_W'(FIRST_FREE + 2), 8'h00, 32'h0);
      send_req(KIND_SPAWN,   ID_W'(FIRST_FREE + 2), 8'h7F, 32'h0F0F_F0F0);
      send_req(KIND_SPARE_5, FIRST_FREE,          8'h00, 32'h0);
      send_req(KIND_SPARE_6, ID_W'(FIRST_FREE + 2), 8'h00, 32'h0);
      send_req(KIND_SPARE_7, ID_MAX,              8'h00, 32'h0);
      send_req(KIND_DESTROY, FIRST_FREE,          8'h00, 32'h0);
      send_req(KIND_GET,     FIRST_FREE,          8'h00, 32'h0);

      // mixed traffic, with a stretch of back-to-back requests
      random_phase(120, 30, 20);
      no_idle = 1'b1;
      random_phase(60, 30, 20);
      no_idle = 1'b0;
      random_phase(80, 30, 20);
      // create-heavy to drain the free list, with one long receiver hold-off
      hold_request = 1'b1;
      random_phase(300, 80, 5);
      // destroy-heavy to refill it
      random_phase(170, 10, 45);

      req_valid <= 1'b0;
      while (checked_count < sent_count) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("summary: %0d requests checked, %0d creates on an empty list, %0d broadcasts,",
               checked_count, empty_create_count, announce_count);
      $display("         %0d out-of-range ids, one %0d-cycle response hold-off under load",
               out_of_range_count, HOLD_CYCLES);
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
rtl/esfa_pkg.sv
rtl/esfa_slot_update.sv
rtl/entity_slot_freelist_allocator_core.sv
dv/slot_alloc_checker.sv
dv/testbench.sv
